// ===== sv/cbtg_pkg.sv =====
// shared constants, types and helpers of the chirp bpsk tone generator
`default_nettype none
package cbtg_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int PHASE_BITS_DEF       = 32;

	localparam int START_INC_W = 47;
	localparam int STEP_W      = 48;
	localparam int VOLUME_W    = 16;
	localparam int SAMPLE_W    = 16;
	localparam int ANGLE_W     = 32;
	localparam int CFG_ADDR_W  = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_START_INC = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CHIRP     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VOLUME    = 2'd2;

	localparam logic [VOLUME_W-1:0] VOLUME_RESET = 16'd16384;

	localparam int CORDIC_W     = 34;
	localparam int CORDIC_ITERS = 16;
	localparam int MAG_W        = 31;
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

	localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [0:CORDIC_ITERS-1] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458908, 34'sd85004757,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
	};

	localparam int FULL_SCALE = 32767;
	localparam int ROUND_BIT  = 44;
	localparam int SCALE_SHR  = 45;

	localparam int FIFO_DEPTH = 32;

	typedef logic signed [CORDIC_W-1:0] cordic_t;

	// arithmetic shift right that truncates toward zero
	function automatic cordic_t shr_tz(input cordic_t v, input int unsigned s);
		cordic_t mag;
		cordic_t r;
		mag = v[CORDIC_W-1] ? -v : v;
		r   = cordic_t'(mag >>> s);
		return v[CORDIC_W-1] ? -r : r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cbtg_phase_state.sv =====
// phase accumulator and phase step held in a one-entry memory, read-modify-write per word
`default_nettype none
module cbtg_phase_state #(
	parameter int SINE_TABLE_DEPTH = cbtg_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int PHASE_BITS       = cbtg_pkg::PHASE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 accept,
	input  wire logic                                 data_bit,
	input  wire logic                                 restart,
	input  wire logic [cbtg_pkg::START_INC_W-1:0]     start_inc,
	input  wire logic [cbtg_pkg::STEP_W-1:0]          chirp,
	output logic                                      vld,
	output logic [cbtg_pkg::ANGLE_W-1:0]              angle
);

	localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int ENTRY_W = PHASE_BITS + cbtg_pkg::STEP_W;

	logic [ENTRY_W-1:0] mem [0:0];
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] fwd_q;
	logic               wr_last_q;
	logic               init_q;

	logic [ENTRY_W-1:0]              cur;
	logic [PHASE_BITS-1:0]           acc;
	logic [cbtg_pkg::STEP_W-1:0]     step;
	logic [PHASE_BITS-1:0]           ph;
	logic [cbtg_pkg::STEP_W-1:0]     new_step;
	logic [PHASE_BITS-1:0]           new_acc;
	logic [ENTRY_W-1:0]              new_entry;

	always_comb begin
		if (wr_last_q) begin
			cur = fwd_q;
		end else if (init_q) begin
			cur = rd_q;
		end else begin
			cur = '0;
		end
		if (restart) begin
			acc  = '0;
			step = {1'b0, start_inc};
		end else begin
			acc  = cur[PHASE_BITS-1:0];
			step = cur[ENTRY_W-1:PHASE_BITS];
		end
		ph        = {acc[PHASE_BITS-1] ^ data_bit, acc[PHASE_BITS-2:0]};
		new_step  = step + chirp;
		new_acc   = acc + new_step[cbtg_pkg::STEP_W-1 -: PHASE_BITS];
		new_entry = {new_step, new_acc};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[0] <= new_entry;
		end
		rd_q <= mem[0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_q <= new_entry;
			angle <= {ph[PHASE_BITS-1 -: ADDR_W], {(cbtg_pkg::ANGLE_W-ADDR_W){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_last_q <= 1'b0;
			init_q    <= 1'b0;
			vld       <= 1'b0;
		end else begin
			wr_last_q <= accept;
			vld       <= accept;
			if (accept) begin
				init_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/cbtg_cordic.sv =====
// pipelined rotation cordic, one iteration per stage, gives sine magnitude and sign
`default_nettype none
module cbtg_cordic (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_vld,
	input  wire logic [cbtg_pkg::ANGLE_W-1:0]     angle,
	output logic                                  out_vld,
	output logic [cbtg_pkg::MAG_W-1:0]            mag,
	output logic                                  neg
);

	localparam int N = cbtg_pkg::CORDIC_ITERS;

	cbtg_pkg::cordic_t x_s [0:N];
	cbtg_pkg::cordic_t y_s [0:N];
	cbtg_pkg::cordic_t z_s [0:N];
	logic              neg_s [0:N];
	logic              vld_s [0:N];

	logic [cbtg_pkg::ANGLE_W-1:0] folded;
	logic                         fold_neg;
	logic [cbtg_pkg::ANGLE_W-1:0] quarter_test;

	// fold to [-1/4, 1/4) turn
	always_comb begin
		quarter_test = angle + 32'h4000_0000;
		fold_neg     = quarter_test[cbtg_pkg::ANGLE_W-1];
		folded       = fold_neg ? angle - 32'h8000_0000 : angle;
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= cbtg_pkg::CORDIC_X0;
		y_s[0]   <= '0;
		z_s[0]   <= cbtg_pkg::cordic_t'($signed(folded));
		neg_s[0] <= fold_neg;
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		cbtg_pkg::cordic_t dx;
		cbtg_pkg::cordic_t dy;
		always_comb begin
			dx = cbtg_pkg::shr_tz(y_s[i], i);
			dy = cbtg_pkg::shr_tz(x_s[i], i);
		end
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!z_s[i][cbtg_pkg::CORDIC_W-1]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - cbtg_pkg::ATAN_TURNS[i];
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + cbtg_pkg::ATAN_TURNS[i];
			end
		end
	end

	cbtg_pkg::cordic_t y_abs;
	always_comb begin
		y_abs = y_s[N][cbtg_pkg::CORDIC_W-1] ? -y_s[N] : y_s[N];
	end

	always_ff @(posedge clk) begin
		mag <= y_abs[cbtg_pkg::MAG_W-1:0];
		neg <= neg_s[N] ^ y_s[N][cbtg_pkg::CORDIC_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= N; j++) begin
				vld_s[j] <= 1'b0;
			end
			out_vld <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int j = 0; j < N; j++) begin
				vld_s[j+1] <= vld_s[j];
			end
			out_vld <= vld_s[N];
		end
	end

endmodule
`default_nettype wire

// ===== sv/cbtg_scale.sv =====
// volume gain, full-scale product, rounding, saturation and sign
`default_nettype none
module cbtg_scale (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_vld,
	input  wire logic [cbtg_pkg::MAG_W-1:0]        mag,
	input  wire logic                              neg,
	input  wire logic [cbtg_pkg::VOLUME_W-1:0]     volume,
	output logic                                   out_vld,
	output logic [cbtg_pkg::SAMPLE_W-1:0]          sample
);

	localparam int PROD_W = cbtg_pkg::MAG_W + cbtg_pkg::VOLUME_W;
	localparam int FS_W   = 15;
	localparam int FULL_W = PROD_W + FS_W;
	localparam int V_W    = FULL_W - cbtg_pkg::SCALE_SHR;

	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;
	logic              vld_s1;
	logic [FULL_W-1:0] full_s2;
	logic              neg_s2;
	logic              vld_s2;

	logic [FULL_W-1:0]               rounded;
	logic [V_W-1:0]                  v;
	logic [cbtg_pkg::SAMPLE_W-1:0]   sat;

	// round, take the sample bits and saturate at full scale; the times 32767 shift and subtract is registered below
	always_comb begin
		rounded = full_s2 + (FULL_W'(1) << cbtg_pkg::ROUND_BIT);
		v       = rounded[FULL_W-1:cbtg_pkg::SCALE_SHR];
		if (v > V_W'(cbtg_pkg::FULL_SCALE)) begin
			sat = cbtg_pkg::SAMPLE_W'(cbtg_pkg::FULL_SCALE);
		end else begin
			sat = v[cbtg_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mag) * PROD_W'(volume);
		neg_s1  <= neg;
		full_s2 <= {prod_s1, {FS_W{1'b0}}} - FULL_W'(prod_s1);
		neg_s2  <= neg_s1;
		sample  <= neg_s2 ? -sat : sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

endmodule
`default_nettype wire

// ===== sv/cbtg_out_fifo.sv =====
// output word queue with credit count of words in flight
`default_nettype none
module cbtg_out_fifo (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_accept,
	output logic                                  in_ready,
	input  wire logic                             push,
	input  wire logic [cbtg_pkg::SAMPLE_W-1:0]    push_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [cbtg_pkg::SAMPLE_W-1:0]         out_data
);

	localparam int DEPTH = cbtg_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [cbtg_pkg::SAMPLE_W-1:0] mem [0:DEPTH-1];
	logic [cbtg_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] rd_ptr_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] credit_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign rd_ptr_d  = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
	assign out_data  = rd_data_q;
	assign in_ready  = (credit_q < CNT_W'(DEPTH));

	// read the head for the next cycle, taking a word written to that entry now
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (push && (wr_ptr_q == rd_ptr_d)) begin
			rd_data_q <= push_data;
		end else begin
			rd_data_q <= mem[rd_ptr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
			case ({in_accept, pop})
				2'b10:   credit_q <= credit_q + CNT_W'(1);
				2'b01:   credit_q <= credit_q - CNT_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/chirp_bpsk_tone_generator.sv =====
// Linear chirp tone generator with bpsk phase flips.
// Each input word on s_axis is one sample tick: tdata[0] is the data bit, which
// adds a half turn to this sample's phase, and tdata[1] is restart, which clears
// the phase and reloads the phase step from start_increment first. Each input
// word yields one signed 16-bit sample word on m_axis, in order.
// Configuration registers (start_increment, chirp_step, volume) are to be
// written through cfg_we / cfg_addr / cfg_wdata only while the block is idle;
// the block itself does not enforce this. Throughput: one word per cycle while
// s_axis_tready is high. The phase and step state lives in a one-entry memory
// updated by a read-modify-write with forwarding. An accepted word passes the
// phase register, the fold stage, 16 cordic stages, the cordic output register,
// 3 scaling stages and the output queue. A 32-entry output queue with a credit
// count keeps s_axis_tready high while fewer than 32 words are in flight or
// waiting, so a stalled receiver holds off input only at 32, and nothing is lost.
// Reset clears the phase and step to zero, volume to 16384 (half scale), other
// registers to zero, and empties the queue.
`default_nettype none
module chirp_bpsk_tone_generator #(
	parameter int SINE_TABLE_DEPTH = cbtg_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int PHASE_BITS       = cbtg_pkg::PHASE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [7:0]                          s_axis_tdata,  // data_bit, restart
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [cbtg_pkg::SAMPLE_W-1:0]            m_axis_tdata,  // sample
	input  wire logic                                cfg_we,
	input  wire logic [cbtg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [cbtg_pkg::STEP_W-1:0]         cfg_wdata
);

	logic [cbtg_pkg::START_INC_W-1:0] start_inc_q;
	logic [cbtg_pkg::STEP_W-1:0]      chirp_q;
	logic [cbtg_pkg::VOLUME_W-1:0]    volume_q;

	logic                             in_accept;
	logic                             ang_vld;
	logic [cbtg_pkg::ANGLE_W-1:0]     angle;
	logic                             mag_vld;
	logic [cbtg_pkg::MAG_W-1:0]       mag;
	logic                             mag_neg;
	logic                             smp_vld;
	logic [cbtg_pkg::SAMPLE_W-1:0]    smp;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_inc_q <= '0;
			chirp_q     <= '0;
			volume_q    <= cbtg_pkg::VOLUME_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				cbtg_pkg::REG_START_INC: start_inc_q <= cfg_wdata[cbtg_pkg::START_INC_W-1:0];
				cbtg_pkg::REG_CHIRP:     chirp_q     <= cfg_wdata;
				cbtg_pkg::REG_VOLUME:    volume_q    <= cfg_wdata[cbtg_pkg::VOLUME_W-1:0];
				default:                 volume_q    <= volume_q;
			endcase
		end
	end

	cbtg_phase_state #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_BITS       (PHASE_BITS)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.data_bit  (s_axis_tdata[0]),
		.restart   (s_axis_tdata[1]),
		.start_inc (start_inc_q),
		.chirp     (chirp_q),
		.vld       (ang_vld),
		.angle     (angle)
	);

	cbtg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (ang_vld),
		.angle   (angle),
		.out_vld (mag_vld),
		.mag     (mag),
		.neg     (mag_neg)
	);

	cbtg_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (mag_vld),
		.mag     (mag),
		.neg     (mag_neg),
		.volume  (volume_q),
		.out_vld (smp_vld),
		.sample  (smp)
	);

	cbtg_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_ready  (s_axis_tready),
		.push      (smp_vld),
		.push_data (smp),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for the chirp bpsk tone generator: randomized ticks, predicted samples, idle stalls
`default_nettype none
module tb_top;

	localparam logic [cbtg_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int ROTATIONS = 16;
	localparam longint ROT_X0 = 652032874;
	localparam longint ARCTAN [ROTATIONS] = '{
		536870912, 316933406, 167458908, 85004757, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	typedef struct {
		bit          data_bit;
		bit          restart;
		int unsigned gap;
	} tick_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata = '0;  // data_bit, restart
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [cbtg_pkg::SAMPLE_W-1:0]   m_axis_tdata;       // sample
	logic                            cfg_we = 1'b0;
	logic [cbtg_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [cbtg_pkg::STEP_W-1:0]     cfg_wdata = '0;

	// predictor state and register mirror
	logic [31:0]                      acc_phase = '0;
	logic [cbtg_pkg::STEP_W-1:0]      step_now = '0;
	logic [cbtg_pkg::START_INC_W-1:0] cfg_start_inc = '0;
	logic [cbtg_pkg::STEP_W-1:0]      cfg_chirp = '0;
	logic [cbtg_pkg::VOLUME_W-1:0]    cfg_volume = cbtg_pkg::VOLUME_RESET;

	tick_t                         tick_q[$];
	tick_t                         cur;
	logic [cbtg_pkg::SAMPLE_W-1:0] sample_q[$];
	logic [cbtg_pkg::SAMPLE_W-1:0] want;

	bit          in_fire = 1'b0;
	bit          out_fire = 1'b0;
	bit          gap_done = 1'b0;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned stall = 0;
	int unsigned hold_seq = 0;
	int unsigned hold_seen = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned ticks = 0;
	int unsigned restarts = 0;
	int unsigned flips = 0;
	int unsigned checked = 0;
	int unsigned saturated = 0;
	int unsigned settings = 0;

	chirp_bpsk_tone_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint trunc_shr(input longint v, input int unsigned s);
		if (v < 0) return -((-v) >>> s);
		return v >>> s;
	endfunction

	// sine of a 32-bit turn angle, scaled by 2^30
	function automatic longint cordic_sin_q30(input logic [31:0] ang);
		logic [31:0] a;
		logic [31:0] probe;
		longint x, y, z, dx, dy;
		bit flip;
		a = ang;
		flip = 1'b0;
		probe = a + 32'h4000_0000;
		if (probe[31]) begin
			a = a - 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'(signed'(a));
		x = ROT_X0;
		y = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			dx = trunc_shr(y, i);
			dy = trunc_shr(x, i);
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN[i];
			end
		end
		return flip ? -y : y;
	endfunction

	// forms the sample of one tick, applying restart first, and advances phase and step
	function automatic logic [cbtg_pkg::SAMPLE_W-1:0] predict_sample(input bit dbit,
			input bit rst);
		logic [31:0] ph;
		logic [63:0] signed_lvl;
		longint y;
		longint unsigned mag;
		longint unsigned lvl;
		if (rst) begin
			acc_phase = '0;
			step_now = {1'b0, cfg_start_inc};
		end
		ph = acc_phase + (dbit ? 32'h8000_0000 : 32'h0);
		y = cordic_sin_q30({ph[31:22], 22'd0});
		mag = (y < 0) ? -y : y;
		lvl = (mag * 64'd32767 * {48'd0, cfg_volume} + (64'd1 << cbtg_pkg::ROUND_BIT))
			>> cbtg_pkg::SCALE_SHR;
		if (lvl > 64'd32767) begin
			lvl = 64'd32767;
			saturated++;
		end
		signed_lvl = (y < 0) ? -lvl : lvl;
		step_now = step_now + cfg_chirp;
		acc_phase = acc_phase + step_now[cbtg_pkg::STEP_W-1:cbtg_pkg::STEP_W-32];
		return signed_lvl[cbtg_pkg::SAMPLE_W-1:0];
	endfunction

	// input side
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_fire) begin
			s_axis_tvalid <= 1'b1;
		end else if (tx_wait != 0) begin
			s_axis_tvalid <= 1'b0;
			tx_wait <= tx_wait - 1;
		end else if (tick_q.size() == 0) begin
			s_axis_tvalid <= 1'b0;
		end else if (!gap_done && tick_q[0].gap != 0) begin
			s_axis_tvalid <= 1'b0;
			tx_wait <= tick_q[0].gap - 1;
			gap_done <= 1'b1;
		end else begin
			cur = tick_q.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {6'd0, cur.restart, cur.data_bit};
			gap_done <= 1'b0;
		end
	end

	// output side
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			rx_wait <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tready && !out_fire) begin
			m_axis_tready <= 1'b1;
		end else if (m_axis_tready) begin
			stall = rx_idle ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				rx_wait <= stall - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cycles++;
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		out_fire <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sample_q.size() == 0) begin
				errors++;
				$display("%0t: sample with none expected, expected none, actual %0d",
					$time, $signed(m_axis_tdata));
			end else begin
				want = sample_q.pop_front();
				checked++;
				if (m_axis_tdata !== want) begin
					errors++;
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$time, $signed(want), $signed(m_axis_tdata));
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			ticks++;
			if (s_axis_tdata[1]) restarts++;
			if (s_axis_tdata[0]) flips++;
			sample_q.push_back(predict_sample(s_axis_tdata[0], s_axis_tdata[1]));
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d samples outstanding", $time, sample_q.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [cbtg_pkg::CFG_ADDR_W-1:0] idx,
			input logic [cbtg_pkg::STEP_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cbtg_pkg::REG_START_INC: cfg_start_inc = val[cbtg_pkg::START_INC_W-1:0];
			cbtg_pkg::REG_CHIRP:     cfg_chirp = val;
			cbtg_pkg::REG_VOLUME:    cfg_volume = val[cbtg_pkg::VOLUME_W-1:0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [cbtg_pkg::STEP_W-1:0] inc,
			input logic [cbtg_pkg::STEP_W-1:0] chirp,
			input logic [cbtg_pkg::STEP_W-1:0] vol);
		write_reg(cbtg_pkg::REG_START_INC, inc);
		write_reg(cbtg_pkg::REG_CHIRP, chirp);
		write_reg(cbtg_pkg::REG_VOLUME, vol);
		settings++;
	endtask

	task automatic queue_tick(input bit dbit, input bit rst);
		tick_t t;
		t.data_bit = dbit;
		t.restart = rst;
		t.gap = tx_idle ? $urandom_range(0, 15) : 0;
		tick_q.push_back(t);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (tick_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [cbtg_pkg::STEP_W-1:0] rand48();
		return cbtg_pkg::STEP_W'({$urandom(), $urandom()});
	endfunction

	initial begin
		logic [cbtg_pkg::STEP_W-1:0] inc, chirp, vol;
		int n;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: state straight after reset
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		wait_idle();

		// quarter-turn steps at full scale
		setup(48'h4000_0000_0000, '0, 48'd32768);
		queue_tick(1'b0, 1'b1);
		repeat (4) queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b1, 1'b1);
		wait_idle();

		// extreme writes: largest start step, top volume, most negative chirp, random spare write
		write_reg(cbtg_pkg::REG_START_INC, '1);
		write_reg(cbtg_pkg::REG_CHIRP, 48'h8000_0000_0000);
		write_reg(cbtg_pkg::REG_VOLUME, '1);
		write_reg(REG_SPARE, rand48());
		settings++;
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		wait_idle();

		// silent output, largest positive chirp
		setup(48'h0000_0123_4567, 48'h7FFF_FFFF_FFFF, '0);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 3))
				0: inc = rand48();
				1, 2: inc = {16'd0, $urandom()} << $urandom_range(0, 14);
				default: inc = $urandom_range(0, 1) ? '0 : '1;
			endcase
			case ($urandom_range(0, 3))
				0: chirp = rand48();
				1, 2: chirp = cbtg_pkg::STEP_W'($signed($urandom())) >>> $urandom_range(0, 16);
				default: chirp = '0;
			endcase
			vol = ($urandom_range(0, 3) == 0) ? cbtg_pkg::STEP_W'($urandom_range(0, 65535))
				: cbtg_pkg::STEP_W'($urandom_range(0, 32768));
			if (ph == 5) vol = 48'd32768;
			setup(inc, chirp, vol);
			if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, rand48());
			tx_idle = (ph != 0 && ph != 2) ? $urandom_range(0, 3) != 0 : 1'b0;
			rx_idle = (ph != 0) ? $urandom_range(0, 3) != 0 : 1'b0;
			if (ph == 2) hold_seq++;
			n = 110;
			queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			for (int i = 1; i < n; i++)
				queue_tick(1'($urandom_range(0, 1)), $urandom_range(0, 31) == 0);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sample_q.size() != 0) begin
			errors++;
			$display("%0t: %0d samples missing, expected %0d, actual none",
				$time, sample_q.size(), $signed(sample_q[0]));
		end
		$display("ran %0d ticks with %0d restarts and %0d phase flips over %0d settings",
			ticks, restarts, flips, settings);
		$display("checked %0d samples, %0d of them saturated", checked, saturated);
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/cbtg_pkg.sv
sv/cbtg_phase_state.sv
sv/cbtg_cordic.sv
sv/cbtg_scale.sv
sv/cbtg_out_fifo.sv
sv/chirp_bpsk_tone_generator.sv
verif/tb_top.sv
